>>> design/yz0_pkg.sv
// shared types and constants for the yaz0 stream decompressor
package yz0_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 4096;
  localparam int unsigned LANE_BYTES_DEF   = 8;
  localparam int unsigned OUT_BYTES        = 8;

  localparam logic [7:0] LIT_FLAG       = 8'h80;
  localparam logic [8:0] LONG_LEN_BIAS  = 9'h12;
  localparam logic [8:0] SHORT_LEN_BIAS = 9'd2;
  localparam logic [4:0] HEADER_LEN     = 5'd16;
  localparam logic [4:0] SIZE_FIRST     = 5'd4;
  localparam logic [4:0] SIZE_LAST      = 5'd7;
  localparam logic [3:0] CODE_BITS      = 4'd8;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CODE,
    PH_DATA,
    PH_REF2,
    PH_REF3,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIT,
    ST_SETUP,
    ST_RD,
    ST_WR,
    ST_EOT
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       err;
  } push_t;

endpackage

>>> design/yz0_window.sv
// history window memory, one write port and one registered read port
module yz0_window #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/yz0_packer.sv
// packs decoded bytes into output beats and holds the output register
module yz0_packer #(
  parameter int unsigned LANE_BYTES = yz0_pkg::LANE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  yz0_pkg::push_t push,
  output logic           push_ready,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [63:0]    out_bytes,
  output logic [3:0]     out_byte_count,
  output logic           out_last_of_run,
  output logic           out_file_done,
  output logic           out_ref_error
);
  import yz0_pkg::*;

  localparam int unsigned CW = $clog2(LANE_BYTES + 1);
  localparam int unsigned LW = (LANE_BYTES > 1) ? $clog2(LANE_BYTES) : 1;

  logic [7:0]    lane_r [LANE_BYTES];
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_inc;
  logic          full;
  logic          flush;
  logic          out_free;
  logic          fire;
  logic [63:0]   packed_bytes;

  logic          out_valid_r;
  logic [63:0]   out_bytes_r;
  logic [3:0]    out_count_r;
  logic          out_last_r;
  logic          out_done_r;
  logic          out_err_r;

  assign cnt_inc    = cnt_r + 1'b1;
  assign full       = (cnt_inc == CW'(LANE_BYTES));
  assign flush      = push.last || full;
  assign out_free   = !out_valid_r || !out_stall;
  assign push_ready = !flush || out_free;
  assign fire       = push.valid && push_ready;

  // lanes above the current byte read as zero
  for (genvar i = 0; i < OUT_BYTES; i++) begin : g_lane
    if (i < LANE_BYTES) begin : g_used
      always_comb begin
        if (cnt_r == CW'(i)) begin
          packed_bytes[8*i +: 8] = push.data;
        end else if (cnt_r > CW'(i)) begin
          packed_bytes[8*i +: 8] = lane_r[i];
        end else begin
          packed_bytes[8*i +: 8] = 8'h00;
        end
      end
    end else begin : g_unused
      assign packed_bytes[8*i +: 8] = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        cnt_r <= flush ? '0 : cnt_inc;
      end
      if (fire && flush) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !flush) begin
      lane_r[cnt_r[LW-1:0]] <= push.data;
    end
    if (fire && flush) begin
      out_bytes_r <= packed_bytes;
      out_count_r <= 4'(cnt_inc);
      out_last_r  <= push.last;
      out_done_r  <= push.done;
      out_err_r   <= push.err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bytes       = out_bytes_r;
  assign out_byte_count  = out_count_r;
  assign out_last_of_run = out_last_r;
  assign out_file_done   = out_done_r;
  assign out_ref_error   = out_err_r;

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && push_ready && push.last |=> cnt_r == '0)
    else $error("lane count not cleared after last byte of run");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r != 4'd0 && out_count_r <= 4'(LANE_BYTES))
    else $error("output beat byte count out of range");

  a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && !push_ready |-> out_valid_r && out_stall)
    else $error("byte push blocked without a stalled output beat");

endmodule

>>> design/yaz0_stream_decompressor_core.sv
// yaz0 stream decompressor: header parse, token sequencer and copy engine
// header and code bytes are consumed on acceptance; a literal goes through accept, push and token end
// a back-reference goes through setup, then one window read and one push per byte, then token end
// output beats carry up to LANE_BYTES bytes; a stalled output holds the copy engine
// synchronous active-low reset clears all control state; the history window is not cleared
// a restart marker on the input restarts the file without disturbing the window pointer
module yaz0_stream_decompressor_core #(
  parameter int unsigned WINDOW_DEPTH = yz0_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned LANE_BYTES   = yz0_pkg::LANE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_first_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last_of_run,
  output logic        out_file_done,
  output logic        out_ref_error
);
  import yz0_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  state_t        state_r, state_nxt;
  phase_t        phase_r, phase_nxt;
  logic [4:0]    hidx_r, hidx_nxt;
  logic [31:0]   target_r, target_nxt;
  logic [31:0]   produced_r, produced_nxt;
  logic [7:0]    code_r, code_nxt;
  logic [3:0]    left_r, left_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic [11:0]   pdist_r, pdist_nxt;
  logic          err_r, err_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [8:0]    len_r, len_nxt;
  logic [12:0]   back_r, back_nxt;
  logic [7:0]    lit_r, lit_nxt;

  logic          in_acc;
  logic          go_lit;
  logic          go_copy;
  logic [31:0]   room;
  logic [8:0]    len_clip;
  logic          src_ok;
  logic [3:0]    left_dec;
  logic [7:0]    rd_data;
  logic          push_ready;
  logic          push_fire;
  logic          rd_en;
  push_t         push;

  assign in_acc    = in_valid && !in_stall;
  assign room      = target_r - produced_r;
  assign len_clip  = (room < 32'(len_r)) ? room[8:0] : len_r;
  assign src_ok    = produced_r >= 32'(back_r);
  assign left_dec  = (left_r != 4'd0) ? left_r - 4'd1 : 4'd0;
  assign push_fire = push.valid && push_ready;

  // token decode on an accepted byte, with restart applied first, then copy and token-end updates
  always_comb begin
    phase_t      ph;
    logic [4:0]  hi;
    logic [31:0] tg;
    logic [31:0] pr;
    logic [7:0]  cb;
    logic [3:0]  cl;
    logic [7:0]  pe;
    logic [11:0] pd;
    logic        er;
    ph = phase_r;
    hi = hidx_r;
    tg = target_r;
    pr = produced_r;
    cb = code_r;
    cl = left_r;
    pe = pend_r;
    pd = pdist_r;
    er = err_r;
    go_lit    = 1'b0;
    go_copy   = 1'b0;
    lit_nxt   = lit_r;
    len_nxt   = len_r;
    back_nxt  = back_r;
    if (in_first_of_file) begin
      ph = PH_HEADER;
      hi = 5'd0;
      tg = 32'd0;
      pr = 32'd0;
      cb = 8'd0;
      cl = 4'd0;
      pe = 8'd0;
      pd = 12'd0;
      er = 1'b0;
    end
    case (ph)
      PH_HEADER: begin
        if (hi >= SIZE_FIRST && hi <= SIZE_LAST) begin
          tg = {tg[23:0], in_byte};
        end
        hi = hi + 5'd1;
        if (hi >= HEADER_LEN) begin
          hi = HEADER_LEN;
          ph = (tg == 32'd0) ? PH_DONE : PH_CODE;
        end
      end
      PH_CODE: begin
        cb = in_byte;
        cl = CODE_BITS;
        ph = PH_DATA;
      end
      PH_DATA: begin
        if ((cb & LIT_FLAG) != 8'd0) begin
          go_lit  = 1'b1;
          lit_nxt = in_byte;
        end else begin
          pe = in_byte;
          ph = PH_REF2;
        end
      end
      PH_REF2: begin
        if (pe[7:4] != 4'd0) begin
          go_copy  = 1'b1;
          len_nxt  = 9'(pe[7:4]) + SHORT_LEN_BIAS;
          back_nxt = 13'({pe[3:0], in_byte}) + 13'd1;
        end else begin
          pd = {pe[3:0], in_byte};
          ph = PH_REF3;
        end
      end
      PH_REF3: begin
        go_copy  = 1'b1;
        len_nxt  = 9'(in_byte) + LONG_LEN_BIAS;
        back_nxt = 13'(pd) + 13'd1;
      end
      default: begin
        ph = PH_DONE;
      end
    endcase
    if (!in_acc) begin
      go_lit   = 1'b0;
      go_copy  = 1'b0;
      lit_nxt  = lit_r;
      len_nxt  = len_r;
      back_nxt = back_r;
      ph = phase_r;
      hi = hidx_r;
      tg = target_r;
      pr = produced_r;
      cb = code_r;
      cl = left_r;
      pe = pend_r;
      pd = pdist_r;
      er = err_r;
    end
    phase_nxt    = ph;
    hidx_nxt     = hi;
    target_nxt   = tg;
    produced_nxt = pr;
    code_nxt     = cb;
    left_nxt     = cl;
    pend_nxt     = pe;
    pdist_nxt    = pd;
    err_nxt      = er;
    wp_nxt       = wp_r;

    case (state_r)
      ST_SETUP: begin
        len_nxt = len_clip;
        if (len_clip != 9'd0 && !src_ok) begin
          err_nxt = 1'b1;
        end
      end
      ST_LIT, ST_WR: begin
        if (push_fire) begin
          produced_nxt = produced_r + 32'd1;
          wp_nxt       = wp_r + 1'b1;
          len_nxt      = len_r - 9'd1;
        end
      end
      ST_EOT: begin
        code_nxt = {code_r[6:0], 1'b0};
        left_nxt = left_dec;
        if (produced_r == target_r) begin
          phase_nxt = PH_DONE;
        end else if (left_dec == 4'd0) begin
          phase_nxt = PH_CODE;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (go_lit) begin
          state_nxt = ST_LIT;
        end else if (go_copy) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_LIT: begin
        if (push_fire) begin
          state_nxt = ST_EOT;
        end
      end
      ST_SETUP: begin
        state_nxt = (len_clip == 9'd0) ? ST_EOT : ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (push_fire) begin
          state_nxt = (len_r == 9'd1) ? ST_EOT : ST_RD;
        end
      end
      ST_EOT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    push.valid = 1'b0;
    push.data  = 8'h00;
    push.last  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_LIT: begin
        push.valid = 1'b1;
        push.data  = lit_r;
        push.last  = 1'b1;
      end
      ST_RD: begin
        rd_en = 1'b1;
      end
      ST_WR: begin
        push.valid = 1'b1;
        push.data  = src_ok ? rd_data : 8'h00;
        push.last  = (len_r == 9'd1);
      end
      default: begin
      end
    endcase
    push.done = (produced_r + 32'd1) == target_r;
    push.err  = err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= PH_HEADER;
      hidx_r     <= 5'd0;
      target_r   <= 32'd0;
      produced_r <= 32'd0;
      code_r     <= 8'd0;
      left_r     <= 4'd0;
      pend_r     <= 8'd0;
      pdist_r    <= 12'd0;
      err_r      <= 1'b0;
      wp_r       <= '0;
      len_r      <= 9'd0;
      back_r     <= 13'd0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      hidx_r     <= hidx_nxt;
      target_r   <= target_nxt;
      produced_r <= produced_nxt;
      code_r     <= code_nxt;
      left_r     <= left_nxt;
      pend_r     <= pend_nxt;
      pdist_r    <= pdist_nxt;
      err_r      <= err_nxt;
      wp_r       <= wp_nxt;
      len_r      <= len_nxt;
      back_r     <= back_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lit_r <= lit_nxt;
  end

  yz0_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (push_fire),
    .wr_addr (wp_r),
    .wr_data (push.data),
    .rd_en   (rd_en),
    .rd_addr (wp_r - back_r[AW-1:0]),
    .rd_data (rd_data)
  );

  yz0_packer #(
    .LANE_BYTES (LANE_BYTES)
  ) u_packer (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .push_ready      (push_ready),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_bytes       (out_bytes),
    .out_byte_count  (out_byte_count),
    .out_last_of_run (out_last_of_run),
    .out_file_done   (out_file_done),
    .out_ref_error   (out_ref_error)
  );

  a_copy_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR |-> produced_r < target_r)
    else $error("copy byte pushed past the declared size");

  a_early_ref_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR && !src_ok |-> err_r)
    else $error("reference before start of output not flagged");

  a_done_at_size: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> produced_r == target_r)
    else $error("decoder done before the declared size was reached");

endmodule

>>> sim/tb_yaz0_stream_decompressor_core.sv
// self-checking testbench for the yaz0 stream decompressor core
module tb_yaz0_stream_decompressor_core;
  import yz0_pkg::*;

  typedef struct packed {
    logic [7:0] val;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  cnt;
    logic        last;
    logic        done;
    logic        err;
  } beat_t;

  localparam int RUN_LIMIT = 20_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_first_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_bytes;
  logic [3:0]  out_byte_count;
  logic        out_last_of_run;
  logic        out_file_done;
  logic        out_ref_error;

  yaz0_stream_decompressor_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_first_of_file (in_first_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bytes        (out_bytes),
    .out_byte_count   (out_byte_count),
    .out_last_of_run  (out_last_of_run),
    .out_file_done    (out_file_done),
    .out_ref_error    (out_ref_error)
  );

  in_item_t stream_q[$];
  beat_t    expected_beats[$];
  beat_t    step_beats[$];
  int       fail_count = 0;

  // decoder shadow state
  logic [7:0]  hist [0:4095];
  logic [11:0] wr_ptr = '0;
  logic [7:0]  code_reg = '0;
  int          bits_left = 0;
  phase_t      phase = PH_HEADER;
  int          hdr_idx = 0;
  logic [31:0] target = '0;
  logic [31:0] produced = '0;
  logic [7:0]  ref_hi = '0;
  logic [11:0] ref_dist = '0;
  logic        err_seen = 1'b0;
  logic [63:0] lane = '0;
  int          lane_n = 0;

  task close_beat();
    beat_t bt;
    bt.bytes = lane;
    bt.cnt   = 4'(lane_n);
    bt.last  = 1'b0;
    bt.done  = (produced == target);
    bt.err   = err_seen;
    step_beats.push_back(bt);
    lane   = '0;
    lane_n = 0;
  endtask

  task emit_byte(input logic [7:0] v);
    hist[wr_ptr] = v;
    wr_ptr   = wr_ptr + 12'd1;
    produced = produced + 32'd1;
    lane[8*lane_n +: 8] = v;
    lane_n++;
    if (lane_n >= LANE_BYTES_DEF) close_beat();
  endtask

  task next_token();
    code_reg = code_reg << 1;
    if (bits_left > 0) bits_left--;
    if (produced == target) phase = PH_DONE;
    else if (bits_left == 0) phase = PH_CODE;
    else phase = PH_DATA;
  endtask

  task copy_match(input logic [11:0] d, input logic [31:0] len);
    logic [31:0] back;
    logic [31:0] room;
    logic [31:0] n;
    logic [7:0]  v;
    back = 32'(d) + 32'd1;
    room = target - produced;
    n = (len > room) ? room : len;
    // source before the first byte of this file reads as zero
    if (n > 0 && produced < back) err_seen = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      v = 8'h00;
      if (produced >= back) v = hist[wr_ptr - back[11:0]];
      emit_byte(v);
    end
    next_token();
  endtask

  task decode_byte(input logic [7:0] b, input logic first);
    beat_t bt;
    logic [11:0] d;
    step_beats.delete();
    lane   = '0;
    lane_n = 0;
    if (first) begin
      phase     = PH_HEADER;
      hdr_idx   = 0;
      target    = '0;
      produced  = '0;
      code_reg  = '0;
      bits_left = 0;
      ref_hi    = '0;
      ref_dist  = '0;
      err_seen  = 1'b0;
    end
    case (phase)
      PH_HEADER: begin
        if (hdr_idx >= SIZE_FIRST && hdr_idx <= SIZE_LAST) target = {target[23:0], b};
        hdr_idx++;
        if (hdr_idx >= HEADER_LEN) begin
          hdr_idx = HEADER_LEN;
          phase = (target == 0) ? PH_DONE : PH_CODE;
        end
      end
      PH_CODE: begin
        code_reg  = b;
        bits_left = CODE_BITS;
        phase     = PH_DATA;
      end
      PH_DATA: begin
        if ((code_reg & LIT_FLAG) != 0) begin
          emit_byte(b);
          next_token();
        end else begin
          ref_hi = b;
          phase  = PH_REF2;
        end
      end
      PH_REF2: begin
        d = {ref_hi[3:0], b};
        if (ref_hi[7:4] != 4'h0) begin
          copy_match(d, 32'(ref_hi[7:4]) + 32'(SHORT_LEN_BIAS));
        end else begin
          ref_dist = d;
          phase    = PH_REF3;
        end
      end
      PH_REF3: copy_match(ref_dist, 32'(b) + 32'(LONG_LEN_BIAS));
      default: phase = PH_DONE;
    endcase
    if (lane_n > 0) close_beat();
    if (step_beats.size() > 0) begin
      bt = step_beats.pop_back();
      bt.last = 1'b1;
      step_beats.push_back(bt);
    end
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endtask

  function automatic int pick_len(input bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task add_byte(input logic [7:0] v, input logic first);
    in_item_t it;
    it.val   = v;
    it.first = first;
    stream_q.push_back(it);
  endtask

  // one compressed file; a cut file is followed straight away by a restart
  task automatic gen_file(input logic [31:0] size, input bit big, input int cut);
    in_item_t    body[$];
    logic [31:0] made;
    logic [7:0]  code;
    int unsigned offs;
    int unsigned len;
    int unsigned span;
    int          limit;
    limit = (cut > 0) ? cut : 32'h7fff_ffff;
    made  = '0;
    body.push_back('{val: 8'($urandom), first: 1'b1});
    for (int i = 1; i < 16; i++) begin
      if (i >= 4 && i <= 7) body.push_back('{val: 8'(size >> (8 * (7 - i))), first: 1'b0});
      else body.push_back('{val: 8'($urandom), first: 1'b0});
    end
    while (made < size && body.size() < limit) begin
      code = big ? (8'($urandom) & 8'h11) : 8'($urandom);
      body.push_back('{val: code, first: 1'b0});
      for (int k = 7; k >= 0 && made < size; k--) begin
        if (code[k]) begin
          body.push_back('{val: 8'($urandom), first: 1'b0});
          made++;
        end else begin
          if (!big && $urandom_range(0, 9) < 7) len = $urandom_range(3, 17);
          else len = $urandom_range(18, 273);
          span = (made > 4096) ? 4096 : made;
          if (span > 0 && $urandom_range(0, 9) != 0) offs = $urandom_range(0, span - 1);
          else offs = $urandom_range(0, 4095);
          if (len <= 17) begin
            body.push_back('{val: {4'(len - 2), 4'(offs >> 8)}, first: 1'b0});
            body.push_back('{val: 8'(offs), first: 1'b0});
          end else begin
            body.push_back('{val: {4'h0, 4'(offs >> 8)}, first: 1'b0});
            body.push_back('{val: 8'(offs), first: 1'b0});
            body.push_back('{val: 8'(len - 18), first: 1'b0});
          end
          made += len;
        end
      end
    end
    while (body.size() > limit) void'(body.pop_back());
    foreach (body[i]) stream_q.push_back(body[i]);
    // trailing bytes after the declared size are ignored
    if (cut == 0) begin
      repeat ($urandom_range(0, 2)) add_byte(8'($urandom), 1'b0);
    end
  endtask

  // input driver
  int gap_left = 0;
  bit in_calm  = 1'b0;
  in_item_t cur_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid         <= 1'b0;
      in_byte          <= 8'h00;
      in_first_of_file <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte, in_first_of_file);
        if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stream_q.size() > 0) begin
          cur_item = stream_q.pop_front();
          in_valid         <= 1'b1;
          in_byte          <= cur_item.val;
          in_first_of_file <= cur_item.first;
          gap_left = in_calm ? 0 : pick_len(1'b1);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall generator
  int    stall_left = 0;
  bit    out_calm   = 1'b0;
  beat_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected output beat: out_bytes %h count %0d", out_bytes, out_byte_count);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_bytes !== want.bytes) begin
            $error("out_bytes: expected %h, got %h", want.bytes, out_bytes);
            fail_count++;
          end
          if (out_byte_count !== want.cnt) begin
            $error("out_byte_count: expected %0d, got %0d", want.cnt, out_byte_count);
            fail_count++;
          end
          if (out_last_of_run !== want.last) begin
            $error("out_last_of_run: expected %b, got %b", want.last, out_last_of_run);
            fail_count++;
          end
          if (out_file_done !== want.done) begin
            $error("out_file_done: expected %b, got %b", want.done, out_file_done);
            fail_count++;
          end
          if (out_ref_error !== want.err) begin
            $error("out_ref_error: expected %b, got %b", want.err, out_ref_error);
            fail_count++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!out_calm && $urandom_range(0, 3) == 0) stall_left = pick_len(1'b0);
      end
    end
  end

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("yaz0_stream_decompressor_core regression: fail");
    $finish;
  end

  initial begin
    int r;
    // header abandoned after two bytes by a restart
    add_byte(8'h59, 1'b1);
    add_byte(8'h61, 1'b0);
    // six-byte file: literal, overlapping short copy, long copy from before the start
    add_byte(8'h00, 1'b1);
    repeat (3) add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h06, 1'b0);
    repeat (8) add_byte(8'hFF, 1'b0);
    add_byte(LIT_FLAG, 1'b0);
    add_byte(8'hA5, 1'b0);
    add_byte(8'h10, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h0F, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h3C, 1'b0);

    // zero declared size, then one file that wraps the history window
    gen_file(32'd0, 1'b0, 0);
    gen_file(32'($urandom_range(4200, 4600)), 1'b1, 0);
    while (stream_q.size() < 260) begin
      r = $urandom_range(0, 99);
      if (r < 8) gen_file(32'd0, 1'b0, 0);
      else if (r < 14) gen_file(32'($urandom), 1'b0, $urandom_range(1, 40));
      else if (r < 22) gen_file(32'($urandom_range(1, 200)), 1'b0, $urandom_range(1, 40));
      else if (r < 32) gen_file(32'($urandom_range(120, 600)), 1'b0, 0);
      else gen_file(32'($urandom_range(1, 120)), 1'b0, 0);
    end

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (stream_q.size() != 0 || in_valid || expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("yaz0_stream_decompressor_core regression: pass");
    end else begin
      $display("yaz0_stream_decompressor_core regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/yz0_pkg.sv
design/yz0_window.sv
design/yz0_packer.sv
design/yaz0_stream_decompressor_core.sv
sim/tb_yaz0_stream_decompressor_core.sv
